>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects signals named clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is held
`define UTD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utd check failed");

// same-cycle implication
`define UTD_ASSERT_IMPL(label, ante, cons) \
    `UTD_ASSERT(label, (ante) |-> (cons))

`endif

>>> hw/rtl/utd_pkg.sv
// shared types and constants of the utf-8 to code point decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utd_pkg;

    localparam int CP_W   = 21;
    localparam int REPS_W = 3;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    // work for one input byte: a run of replacements, then an optional value
    typedef struct packed {
        logic [REPS_W-1:0] reps;
        logic              has_val;
        logic [CP_W-1:0]   value;
        logic              str_end;
    } desc_t;

endpackage

`default_nettype wire

>>> hw/rtl/utd_if.sv
// channel interfaces: byte input and code point output
// depends on utd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       string_end;

    modport source (output valid, output byte_value, output string_end, input ready);
    modport sink   (input valid, input byte_value, input string_end, output ready);
endinterface

interface utd_cp_if;
    logic                       valid;
    logic                       ready;
    logic [utd_pkg::CP_W-1:0]   code_point;
    logic                       run_last;
    logic                       string_last;

    modport source (output valid, output code_point, output run_last, output string_last,
                    input ready);
    modport sink   (input valid, input code_point, input run_last, input string_last,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/utd_front.sv
// front end: accepts bytes, tracks the open sequence, builds at most one descriptor per byte
// depends on utd_pkg and utd_if
`timescale 1ns / 1ps
`default_nettype none

module utd_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    utd_byte_if.sink        byte_ch,
    output logic            push_valid,
    input  wire logic       push_ready,
    output utd_pkg::desc_t  push_desc
);

    logic                       pend_reg, pend_next;
    logic [1:0]                 exp_reg, exp_next;
    logic [1:0]                 coll_reg, coll_next;
    logic [utd_pkg::CP_W-1:0]   pv_reg, pv_next;

    logic [7:0]                 b;
    logic                       is_cont;
    logic [1:0]                 got;
    logic [utd_pkg::CP_W-1:0]   pv_shift;
    logic                       do_start;
    logic [utd_pkg::REPS_W-1:0] reps;
    logic                       has_val;
    logic [utd_pkg::CP_W-1:0]   value;
    logic                       fire;

    assign b        = byte_ch.byte_value;
    assign is_cont  = (b[7:6] == 2'b10);
    assign got      = coll_reg + 2'd1;
    assign pv_shift = {pv_reg[utd_pkg::CP_W-7:0], b[5:0]};

    always_comb
    begin
        pend_next = pend_reg;
        exp_next  = exp_reg;
        coll_next = coll_reg;
        pv_next   = pv_reg;
        reps      = '0;
        has_val   = 1'b0;
        value     = utd_pkg::REPL_CP;
        do_start  = 1'b0;

        if (pend_reg)
        begin
            if (is_cont)
            begin
                if (got >= exp_reg)
                begin
                    has_val   = 1'b1;
                    pend_next = 1'b0;
                    if ((pv_shift >= utd_pkg::SURR_LO && pv_shift <= utd_pkg::SURR_HI) ||
                        pv_shift > utd_pkg::MAX_CP)
                        value = utd_pkg::REPL_CP;
                    else
                        value = pv_shift;
                end
                else
                begin
                    coll_next = got;
                    pv_next   = pv_shift;
                end
            end
            else
            begin
                // broken sequence: lead plus each buffered continuation
                reps      = {1'b0, coll_reg} + utd_pkg::REPS_W'(1);
                pend_next = 1'b0;
                do_start  = 1'b1;
            end
        end
        else
        begin
            do_start = 1'b1;
        end

        if (do_start)
        begin
            unique case (b) inside
                [8'h00:8'h7F]:
                begin
                    has_val = 1'b1;
                    value   = {13'd0, b};
                end
                [8'hC0:8'hDF]:
                begin
                    pend_next = 1'b1;
                    exp_next  = 2'd1;
                    coll_next = 2'd0;
                    pv_next   = {16'd0, b[4:0]};
                end
                [8'hE0:8'hEF]:
                begin
                    pend_next = 1'b1;
                    exp_next  = 2'd2;
                    coll_next = 2'd0;
                    pv_next   = {17'd0, b[3:0]};
                end
                [8'hF0:8'hF7]:
                begin
                    pend_next = 1'b1;
                    exp_next  = 2'd3;
                    coll_next = 2'd0;
                    pv_next   = {18'd0, b[2:0]};
                end
                default:
                begin
                    reps = reps + utd_pkg::REPS_W'(1);
                end
            endcase
        end

        // flush at string end
        if (byte_ch.string_end && pend_next)
        begin
            reps      = reps + utd_pkg::REPS_W'(1) + {1'b0, coll_next};
            pend_next = 1'b0;
        end
    end

    assign byte_ch.ready     = push_ready;
    assign fire              = byte_ch.valid && push_ready;
    assign push_valid        = byte_ch.valid && (has_val || reps != '0);
    assign push_desc.reps    = reps;
    assign push_desc.has_val = has_val;
    assign push_desc.value   = value;
    assign push_desc.str_end = byte_ch.string_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            exp_reg  <= 2'd0;
            coll_reg <= 2'd0;
            pv_reg   <= '0;
        end
        else if (fire)
        begin
            pend_reg <= pend_next;
            exp_reg  <= exp_next;
            coll_reg <= coll_next;
            pv_reg   <= pv_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utd_queue.sv
// descriptor queue between front and back end
// depends on utd_pkg
`timescale 1ns / 1ps
`default_nettype none

module utd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire utd_pkg::desc_t  push_desc,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output utd_pkg::desc_t       pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utd_pkg::desc_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utd_back.sv
// back end: expands descriptors into code points, one beat per cycle unless cp_ch stalls
// depends on utd_pkg and utd_if
`timescale 1ns / 1ps
`default_nettype none

module utd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire utd_pkg::desc_t  pop_desc,
    utd_cp_if.source             cp_ch
);

    logic                       cur_valid_reg, cur_valid_next;
    logic [utd_pkg::REPS_W-1:0] reps_reg, reps_next;
    logic                       has_val_reg, has_val_next;
    logic [utd_pkg::CP_W-1:0]   val_reg, val_next;
    logic                       end_reg, end_next;

    logic                       out_valid_reg, out_valid_next;
    logic [utd_pkg::CP_W-1:0]   cp_reg;
    logic                       run_last_reg;
    logic                       str_last_reg;

    logic                       load_out;
    logic                       rep_now;
    logic                       last_now;
    logic [utd_pkg::CP_W-1:0]   cp_now;
    logic                       cur_done;
    logic                       do_pop;

    assign load_out  = cur_valid_reg && (!out_valid_reg || cp_ch.ready);
    assign rep_now   = (reps_reg != '0);
    assign cp_now    = rep_now ? utd_pkg::REPL_CP : val_reg;
    assign last_now  = rep_now ? (reps_reg == utd_pkg::REPS_W'(1) && !has_val_reg) : 1'b1;
    assign cur_done  = load_out && last_now;
    assign pop_ready = !cur_valid_reg || cur_done;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        reps_next      = reps_reg;
        has_val_next   = has_val_reg;
        val_next       = val_reg;
        end_next       = end_reg;
        if (do_pop)
        begin
            cur_valid_next = 1'b1;
            reps_next      = pop_desc.reps;
            has_val_next   = pop_desc.has_val;
            val_next       = pop_desc.value;
            end_next       = pop_desc.str_end;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load_out && rep_now)
        begin
            reps_next = reps_reg - utd_pkg::REPS_W'(1);
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (cp_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reps_reg    <= reps_next;
        has_val_reg <= has_val_next;
        val_reg     <= val_next;
        end_reg     <= end_next;
        if (load_out)
        begin
            cp_reg       <= cp_now;
            run_last_reg <= last_now;
            str_last_reg <= last_now && end_reg;
        end
    end

    assign cp_ch.valid       = out_valid_reg;
    assign cp_ch.code_point  = cp_reg;
    assign cp_ch.run_last    = run_last_reg;
    assign cp_ch.string_last = str_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_codepoint_decoder_core.sv
// channel   | dir | payload                                  | handshake
// byte_ch   | in  | byte_value[7:0], string_end              | valid/ready
// cp_ch     | out | code_point[20:0], run_last, string_last  | valid/ready
//
// one byte is taken per cycle while the descriptor queue has room
// the back end sends one code point per cycle unless cp_ch stalls, so a byte with n results
// holds its descriptor in the back end until its last code point is loaded (n at most 4)
// results pass through the queue, the back end's descriptor register and its output register
// rst_n clears the open sequence, the queue, the back end's descriptor and the output register
// top level of the utf-8 to code point decoder: front, queue, back
// depends on utd_pkg, utd_if, utd_front, utd_queue, utd_back
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_codepoint_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    utd_byte_if.sink    byte_ch,
    utd_cp_if.source    cp_ch
);

    logic           push_valid;
    logic           push_ready;
    utd_pkg::desc_t push_desc;
    logic           pop_valid;
    logic           pop_ready;
    utd_pkg::desc_t pop_desc;

    utd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    utd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    utd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .cp_ch     (cp_ch)
    );

endmodule

`default_nettype wire

>>> hw/rtl/utd_checker.sv
// port-level checks on the decoder output, bound to the top level
// depends on utd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utd_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [utd_pkg::CP_W-1:0] code_point,
    input wire logic                     run_last,
    input wire logic                     string_last
);

    logic is_scalar;

    assign is_scalar = (code_point <= utd_pkg::MAX_CP) &&
                       (code_point < utd_pkg::SURR_LO || code_point > utd_pkg::SURR_HI);

    // a stalled beat stays up
    `UTD_ASSERT(a_valid_hold, (out_valid && !out_ready) |=> out_valid)
    // and keeps its code point
    `UTD_ASSERT(a_cp_hold, (out_valid && !out_ready) |=> $stable(code_point))
    // end of string is always the end of a byte's run
    `UTD_ASSERT_IMPL(a_str_last_run, out_valid && string_last, run_last)
    // only scalar values leave the block
    `UTD_ASSERT_IMPL(a_scalar, out_valid, is_scalar)

endmodule

bind utf8_to_codepoint_decoder_core utd_checker u_utd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (cp_ch.valid),
    .out_ready   (cp_ch.ready),
    .code_point  (cp_ch.code_point),
    .run_last    (cp_ch.run_last),
    .string_last (cp_ch.string_last)
);

`default_nettype wire
